// ===== design/bfsp_pkg.sv =====
package bfsp_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int WEIGHT_BITS_DEF  = 16;

  localparam int DIST_W     = 20;
  localparam int VFIELD_W   = 4;
  localparam int WFIELD_W   = 16;
  localparam int COUNT_W    = 5;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;
  localparam logic [DIST_W-1:0]  DIST_INF    = 20'hFFFFF;
  localparam logic [DIST_W-1:0]  DIST_MAXFIN = 20'hFFFFE;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_RUN  = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_RELAX,
    ST_DRAIN,
    ST_OUT_RD,
    ST_OUT_WR
  } state_t;

endpackage

// ===== design/bfsp_weight_mem.sv =====
module bfsp_weight_mem #(
  parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS_DEF,
  localparam int VIDX_W      = $clog2(MAX_VERTICES),
  localparam int WA_W        = 2 * VIDX_W
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [WA_W-1:0]        waddr,
  input  logic [WEIGHT_BITS-1:0] wdata,
  input  logic [WA_W-1:0]        raddr,
  output logic [WEIGHT_BITS-1:0] rdata
);

  localparam int DEPTH = 1 << WA_W;

  logic [WEIGHT_BITS-1:0] weights [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      weights[waddr] <= wdata;
    end
    rdata <= weights[raddr];
  end

endmodule

// ===== design/bfsp_dist_mem.sv =====
module bfsp_dist_mem #(
  parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
  localparam int VIDX_W      = $clog2(MAX_VERTICES)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [VIDX_W-1:0]           waddr,
  input  logic [bfsp_pkg::DIST_W-1:0] wdist,
  input  logic [VIDX_W-1:0]           wpar,
  input  logic [VIDX_W-1:0]           ra_addr,
  output logic [bfsp_pkg::DIST_W-1:0] ra_dist,
  output logic [VIDX_W-1:0]           ra_par,
  input  logic [VIDX_W-1:0]           rb_addr,
  output logic [bfsp_pkg::DIST_W-1:0] rb_dist
);

  localparam int DEPTH = 1 << VIDX_W;

  logic [bfsp_pkg::DIST_W-1:0] dist_mem [DEPTH];
  logic [VIDX_W-1:0]           par_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      dist_mem[waddr] <= wdist;
      par_mem[waddr]  <= wpar;
    end
    ra_dist <= dist_mem[ra_addr];
    ra_par  <= par_mem[ra_addr];
    rb_dist <= dist_mem[rb_addr];
  end

endmodule

// ===== design/bfsp_engine.sv =====
module bfsp_engine #(
  parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS_DEF,
  localparam int VIDX_W      = $clog2(MAX_VERTICES),
  localparam int WA_W        = 2 * VIDX_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [VIDX_W-1:0]              n_last,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bfsp_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bfsp_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                           m_tlast,
  output logic                           w_we,
  output logic [WA_W-1:0]                w_waddr,
  output logic [WEIGHT_BITS-1:0]         w_wdata,
  output logic [WA_W-1:0]                w_raddr,
  input  logic [WEIGHT_BITS-1:0]         w_rdata,
  output logic                           d_we,
  output logic [VIDX_W-1:0]              d_waddr,
  output logic [bfsp_pkg::DIST_W-1:0]    d_wdist,
  output logic [VIDX_W-1:0]              d_wpar,
  output logic [VIDX_W-1:0]              d_ra_addr,
  input  logic [bfsp_pkg::DIST_W-1:0]    d_ra_dist,
  input  logic [VIDX_W-1:0]              d_ra_par,
  output logic [VIDX_W-1:0]              d_rb_addr,
  input  logic [bfsp_pkg::DIST_W-1:0]    d_rb_dist
);

  localparam int DIST_W = bfsp_pkg::DIST_W;
  localparam int SUM_W  = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

  bfsp_pkg::state_t  state, state_next;
  bfsp_pkg::opcode_t in_op;

  logic [VIDX_W-1:0] pass_c, u_c, v_c;
  logic [WA_W-1:0]   clr_addr;
  logic [bfsp_pkg::VFIELD_W-1:0] start_reg;

  logic              s1_valid;
  logic [VIDX_W-1:0] s1_u, s1_v;
  logic              byp_a_hit, byp_b_hit;
  logic [DIST_W-1:0] byp_dist;

  logic [bfsp_pkg::VFIELD_W-1:0] in_row, in_col, in_start;
  logic [bfsp_pkg::WFIELD_W-1:0] in_weight;
  logic [VIDX_W+3:0]             row_ext, col_ext;
  logic [WEIGHT_BITS+15:0]       w_ext;
  logic                          in_range;

  logic [DIST_W-1:0] du, dv, cand;
  logic [SUM_W-1:0]  sum;
  logic              relax_we;
  logic              out_load;
  logic [VIDX_W+3:0] vidx_ext, par_ext;

  assign in_op     = bfsp_pkg::opcode_t'(s_tuser);
  assign in_row    = s_tdata[3:0];
  assign in_col    = s_tdata[7:4];
  assign in_weight = s_tdata[23:8];
  assign in_start  = s_tdata[27:24];
  assign row_ext   = {{VIDX_W{1'b0}}, in_row};
  assign col_ext   = {{VIDX_W{1'b0}}, in_col};
  assign w_ext     = {{WEIGHT_BITS{1'b0}}, in_weight};
  assign in_range  = ({28'd0, in_row} < 32'(MAX_VERTICES))
                  && ({28'd0, in_col} < 32'(MAX_VERTICES));

  // Relaxation stage, fed by the registered memory reads plus write forwarding.
  assign du       = byp_a_hit ? byp_dist : d_ra_dist;
  assign dv       = byp_b_hit ? byp_dist : d_rb_dist;
  assign sum      = SUM_W'(du) + SUM_W'(w_rdata);
  assign cand     = (sum > SUM_W'(bfsp_pkg::DIST_MAXFIN)) ? bfsp_pkg::DIST_MAXFIN
                                                           : sum[DIST_W-1:0];
  assign relax_we = s1_valid && (s1_u != s1_v) && (w_rdata != '0)
                 && (du != bfsp_pkg::DIST_INF) && (cand < dv);

  assign vidx_ext = {4'd0, v_c};
  assign par_ext  = {4'd0, d_ra_par};

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    w_we       = 1'b0;
    w_waddr    = {u_c, v_c};
    w_wdata    = '0;
    w_raddr    = {u_c, v_c};
    d_we       = relax_we;
    d_waddr    = s1_v;
    d_wdist    = cand;
    d_wpar     = s1_u;
    d_ra_addr  = u_c;
    d_rb_addr  = v_c;
    out_load   = 1'b0;
    case (state)
      bfsp_pkg::ST_CLEAR: begin
        w_we    = 1'b1;
        w_waddr = clr_addr;
        if (&clr_addr) begin
          state_next = bfsp_pkg::ST_IDLE;
        end
      end
      bfsp_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (in_op == bfsp_pkg::OP_RUN) begin
            state_next = bfsp_pkg::ST_INIT;
          end else if (in_range) begin
            w_we    = 1'b1;
            w_waddr = {row_ext[VIDX_W-1:0], col_ext[VIDX_W-1:0]};
            w_wdata = w_ext[WEIGHT_BITS-1:0];
          end
        end
      end
      bfsp_pkg::ST_INIT: begin
        d_we    = 1'b1;
        d_waddr = v_c;
        d_wdist = (32'(v_c) == 32'(start_reg)) ? '0 : bfsp_pkg::DIST_INF;
        d_wpar  = '0;
        if (v_c == n_last) begin
          state_next = bfsp_pkg::ST_RELAX;
        end
      end
      bfsp_pkg::ST_RELAX: begin
        if ((v_c == n_last) && (u_c == n_last) && (pass_c == n_last)) begin
          state_next = bfsp_pkg::ST_DRAIN;
        end
      end
      bfsp_pkg::ST_DRAIN: begin
        state_next = bfsp_pkg::ST_OUT_RD;
      end
      bfsp_pkg::ST_OUT_RD: begin
        d_ra_addr  = v_c;
        state_next = bfsp_pkg::ST_OUT_WR;
      end
      bfsp_pkg::ST_OUT_WR: begin
        d_ra_addr = v_c;
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = (v_c == n_last) ? bfsp_pkg::ST_IDLE : bfsp_pkg::ST_OUT_RD;
        end
      end
      default: begin
        state_next = bfsp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bfsp_pkg::ST_CLEAR;
      clr_addr  <= '0;
      pass_c    <= '0;
      u_c       <= '0;
      v_c       <= '0;
      s1_valid  <= 1'b0;
      byp_a_hit <= 1'b0;
      byp_b_hit <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      s1_valid  <= (state == bfsp_pkg::ST_RELAX);
      byp_a_hit <= relax_we && (s1_v == d_ra_addr);
      byp_b_hit <= relax_we && (s1_v == d_rb_addr);
      case (state)
        bfsp_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
        end
        bfsp_pkg::ST_IDLE: begin
          v_c <= '0;
        end
        bfsp_pkg::ST_INIT: begin
          if (v_c == n_last) begin
            v_c    <= '0;
            u_c    <= '0;
            pass_c <= '0;
          end else begin
            v_c <= v_c + 1'b1;
          end
        end
        bfsp_pkg::ST_RELAX: begin
          if (v_c == n_last) begin
            v_c <= '0;
            if (u_c == n_last) begin
              u_c    <= '0;
              pass_c <= pass_c + 1'b1;
            end else begin
              u_c <= u_c + 1'b1;
            end
          end else begin
            v_c <= v_c + 1'b1;
          end
        end
        bfsp_pkg::ST_OUT_WR: begin
          if (out_load && (v_c != n_last)) begin
            v_c <= v_c + 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_u     <= u_c;
    s1_v     <= v_c;
    byp_dist <= cand;
    if ((state == bfsp_pkg::ST_IDLE) && s_tvalid && (in_op == bfsp_pkg::OP_RUN)) begin
      start_reg <= in_start;
    end
    if (out_load) begin
      m_tdata <= {3'd0, par_ext[3:0], (d_ra_dist != bfsp_pkg::DIST_INF),
                  d_ra_dist, vidx_ext[3:0]};
      m_tlast <= (v_c == n_last);
    end
  end

endmodule

// ===== design/bellman_ford_shortest_paths_top.sv =====
// Load transaction: while the engine is idle, one matrix weight per cycle back to back.
// Run transaction: setup, N relaxation passes over all N*N vertex pairs and a drain, then each
// result is read and written out, where N is the active vertex count; one relaxation per cycle.
// Results leave through an output register; the last one may wait while new input is taken.
// Reset (synchronous, rst high) sets vertex_count to 16 and starts a clearing pass that zeroes
// all 2**(2*clog2(MAX_VERTICES)) entries (256 by default) of the weight matrix.
module bellman_ford_shortest_paths_top #(
  parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = bfsp_pkg::WEIGHT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bfsp_pkg::COUNT_W-1:0]   cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // row_vertex[3:0], col_vertex[7:4], edge_weight[23:8], start_vertex[27:24], zero[31:28]
  input  logic [bfsp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // opcode[0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // vertex_index[3:0], path_distance[23:4], reachable[24], parent_vertex[28:25], zero[31:29]
  output logic [bfsp_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);

  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int WA_W   = 2 * VIDX_W;

  logic [bfsp_pkg::COUNT_W-1:0] vertex_count;
  logic [VIDX_W-1:0]            n_last;

  logic                        w_we;
  logic [WA_W-1:0]             w_waddr, w_raddr;
  logic [WEIGHT_BITS-1:0]      w_wdata, w_rdata;
  logic                        d_we;
  logic [VIDX_W-1:0]           d_waddr, d_wpar, d_ra_addr, d_ra_par, d_rb_addr;
  logic [bfsp_pkg::DIST_W-1:0] d_wdist, d_ra_dist, d_rb_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= bfsp_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  always_comb begin
    if (vertex_count == '0) begin
      n_last = '0;
    end else if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
      n_last = VIDX_W'(MAX_VERTICES - 1);
    end else begin
      n_last = VIDX_W'(vertex_count - 1'b1);
    end
  end

  bfsp_weight_mem #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_weight_mem (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  bfsp_dist_mem #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dist_mem (
    .clk     (clk),
    .we      (d_we),
    .waddr   (d_waddr),
    .wdist   (d_wdist),
    .wpar    (d_wpar),
    .ra_addr (d_ra_addr),
    .ra_dist (d_ra_dist),
    .ra_par  (d_ra_par),
    .rb_addr (d_rb_addr),
    .rb_dist (d_rb_dist)
  );

  bfsp_engine #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .n_last    (n_last),
    .s_tvalid  (s_axis_tvalid),
    .s_tready  (s_axis_tready),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .m_tdata   (m_axis_tdata),
    .m_tlast   (m_axis_tlast),
    .w_we      (w_we),
    .w_waddr   (w_waddr),
    .w_wdata   (w_wdata),
    .w_raddr   (w_raddr),
    .w_rdata   (w_rdata),
    .d_we      (d_we),
    .d_waddr   (d_waddr),
    .d_wdist   (d_wdist),
    .d_wpar    (d_wpar),
    .d_ra_addr (d_ra_addr),
    .d_ra_dist (d_ra_dist),
    .d_ra_par  (d_ra_par),
    .d_rb_addr (d_rb_addr),
    .d_rb_dist (d_rb_dist)
  );

  // The weight matrix is being cleared right after reset, so no input may be taken.
  assert property (@(posedge clk) $fell(rst) |-> !s_axis_tready)
    else $error("input taken during the clearing pass");

  // A run occupies the engine in the cycle after it is accepted.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
    else $error("input taken right after a run transaction");

  // The reachable flag agrees with the unreachable distance marker.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[24] == (m_axis_tdata[23:4] != bfsp_pkg::DIST_INF)))
    else $error("reachable flag disagrees with distance");

  // A vertex that was never reached was never relaxed, so its parent is zero.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[24]) |-> (m_axis_tdata[28:25] == 4'd0))
    else $error("unreachable vertex carries a parent");

endmodule
